/* hw/rtl/psl_pkg.sv */
// Shared types and constants for the Pascal subset lexer.
// No dependencies.
package psl_pkg;

    localparam int KwMaxLen   = 9;
    localparam int CountWidth = 16;
    localparam int LenWidth   = $clog2(KwMaxLen + 1);

    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_WORD  = 3'd1;
    localparam logic [2:0] M_INT   = 3'd2;
    localparam logic [2:0] M_FRAC  = 3'd3;
    localparam logic [2:0] M_BRACE = 3'd4;
    localparam logic [2:0] M_PCOM  = 3'd5;
    localparam logic [2:0] M_PSTAR = 3'd6;
    localparam logic [2:0] M_HOLD  = 3'd7;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    localparam logic [6:0] TK_IDENT  = 7'd40;
    localparam logic [6:0] TK_NUMBER = 7'd41;
    localparam logic [6:0] TK_SYMBOL = 7'd42;
    localparam logic [6:0] TK_ASSIGN = 7'd44;
    localparam logic [6:0] TK_INC    = 7'd50;
    localparam logic [6:0] TK_DEC    = 7'd51;
    localparam logic [6:0] TK_NE     = 7'd52;
    localparam logic [6:0] TK_GE     = 7'd53;
    localparam logic [6:0] TK_LE     = 7'd54;
    localparam logic [6:0] TK_NONE   = 7'd0;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  token_code;
        logic [15:0] line_no;
        logic [15:0] col_no;
        logic [15:0] lexeme_length;
        logic [7:0]  first_byte;
        logic        last;
    } t_out_item;

    typedef logic [KwMaxLen*8-1:0] t_prefix;

    function automatic logic [15:0] clip16(input logic [CountWidth-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [6:0] single_code(input logic [7:0] c);
        case (c)
            "+":     return 7'd46;
            "-":     return 7'd47;
            "*":     return 7'd48;
            "/":     return 7'd49;
            "^":     return 7'd55;
            "=":     return 7'd45;
            ";":     return 7'd56;
            ",":     return 7'd57;
            "(":     return 7'd58;
            ")":     return 7'd59;
            "[":     return 7'd60;
            "]":     return 7'd61;
            "{":     return 7'd62;
            "}":     return 7'd63;
            ".":     return 7'd64;
            ":":     return 7'd65;
            default: return TK_SYMBOL;
        endcase
    endfunction

    function automatic logic [6:0] pair_code(input logic [7:0] a, input logic [7:0] b);
        if (a == ":" && b == "=") return TK_ASSIGN;
        if (a == "<" && b == ">") return TK_NE;
        if (a == "<" && b == "=") return TK_LE;
        if (a == ">" && b == "=") return TK_GE;
        if (a == "+" && b == "+") return TK_INC;
        if (a == "-" && b == "-") return TK_DEC;
        return TK_NONE;
    endfunction

    // Keyword text, left aligned, zero padded to KwMaxLen bytes.
    function automatic t_prefix kw_pad(input string s);
        t_prefix p;
        p = '0;
        for (int i = 0; i < s.len(); i++) p[(KwMaxLen-1-i)*8 +: 8] = s[i];
        return p;
    endfunction

    function automatic t_prefix kw_text(input int k);
        case (k)
            0: return kw_pad("program");   1: return kw_pad("read");
            2: return kw_pad("write");     3: return kw_pad("integer");
            4: return kw_pad("boolean");   5: return kw_pad("double");
            6: return kw_pad("function");  7: return kw_pad("procedure");
            8: return kw_pad("begin");     9: return kw_pad("end");
            10: return kw_pad("and");      11: return kw_pad("array");
            12: return kw_pad("case");     13: return kw_pad("const");
            14: return kw_pad("div");      15: return kw_pad("do");
            16: return kw_pad("downto");   17: return kw_pad("else");
            18: return kw_pad("file");     19: return kw_pad("for");
            20: return kw_pad("goto");     21: return kw_pad("if");
            22: return kw_pad("in");       23: return kw_pad("label");
            24: return kw_pad("mod");      25: return kw_pad("nil");
            26: return kw_pad("not");      27: return kw_pad("of");
            28: return kw_pad("or");       29: return kw_pad("packed");
            30: return kw_pad("record");   31: return kw_pad("repeat");
            32: return kw_pad("set");      33: return kw_pad("then");
            34: return kw_pad("to");       35: return kw_pad("type");
            36: return kw_pad("until");    37: return kw_pad("with");
            38: return kw_pad("var");      default: return kw_pad("while");
        endcase
    endfunction

endpackage

/* hw/rtl/pascal_subset_lexer_unit.sv */
// Pascal subset lexer: one input item (byte or end of line) per cycle while o_stall is low.
// Results are registered: they appear in the cycle after the transfer; an item giving two
// tokens holds the input stalled while the second drains from the spill entry.
// Throughput: one item per cycle, limited only by the two-entry result queue.
// Reset (synchronous, active low) returns to idle at line 1, column 1.
// Depends on psl_pkg and psl_kw_match.
module pascal_subset_lexer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  psl_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output psl_pkg::t_out_item o_data
);
    localparam int CW = psl_pkg::CountWidth;
    localparam int KL = psl_pkg::KwMaxLen;
    localparam int LenWidth_l = psl_pkg::LenWidth;

    logic [2:0]       r_mode, n_mode;
    logic [7:0]       r_pend, n_pend;
    psl_pkg::t_prefix r_pfx, n_pfx;
    logic [CW-1:0]    r_start, n_start, r_len, n_len, r_line, n_line, r_col, n_col;

    // Result queue: entry 0 is the output register, entry 1 the spill.
    psl_pkg::t_out_item r_q0, r_q1;
    logic r_v0, r_v1;

    logic [6:0] kw_code;
    psl_kw_match u_kw (.i_prefix(r_pfx), .i_len(r_len), .o_code(kw_code));

    psl_pkg::t_out_item e0, e1;
    logic e0v, e1v;
    logic take;
    logic [7:0] c;

    assign o_stall = r_v1 || (r_v0 && i_stall);
    assign take    = i_valid && !o_stall;
    assign c       = i_data.ch;
    assign o_valid = r_v0;
    assign o_data  = r_q0;

    function automatic psl_pkg::t_out_item mk(input logic [6:0] code,
        input logic [CW-1:0] line, input logic [CW-1:0] col,
        input logic [CW-1:0] len, input logic [7:0] first);
        psl_pkg::t_out_item t;
        t.token_code = code;
        t.line_no = psl_pkg::clip16(line);
        t.col_no = psl_pkg::clip16(col);
        t.lexeme_length = psl_pkg::clip16(len);
        t.first_byte = first;
        t.last = 1'b0;
        return t;
    endfunction

    always_comb begin
        logic do_flush, do_start;
        logic [LenWidth_l-1:0] idx;
        n_mode = r_mode; n_pend = r_pend; n_pfx = r_pfx;
        n_start = r_start; n_len = r_len; n_line = r_line; n_col = r_col;
        e0 = '0; e1 = '0; e0v = 1'b0; e1v = 1'b0;
        do_flush = 1'b0; do_start = 1'b0;
        idx = r_len[LenWidth_l-1:0];
        if (i_data.cmd == psl_pkg::CMD_EOL) begin
            do_flush = 1'b1;
            n_line = psl_pkg::sat_inc(r_line);
            n_col = CW'(1);
        end else begin
            n_col = psl_pkg::sat_inc(r_col);
            case (r_mode)
                psl_pkg::M_BRACE: if (c == "}") n_mode = psl_pkg::M_IDLE;
                psl_pkg::M_PCOM:  if (c == "*") n_mode = psl_pkg::M_PSTAR;
                psl_pkg::M_PSTAR: begin
                    if (c == ")") n_mode = psl_pkg::M_IDLE;
                    else if (c != "*") n_mode = psl_pkg::M_PCOM;
                end
                psl_pkg::M_WORD: begin
                    if (psl_pkg::is_alpha(c) || psl_pkg::is_digit(c) || c == "_") begin
                        if (r_len < CW'(KL)) n_pfx[(KL-1-int'(idx))*8 +: 8] = c;
                        n_len = psl_pkg::sat_inc(r_len);
                    end else begin
                        do_flush = 1'b1; do_start = 1'b1;
                    end
                end
                psl_pkg::M_INT: begin
                    if (psl_pkg::is_digit(c) || c == ".") begin
                        if (c == ".") n_mode = psl_pkg::M_FRAC;
                        n_len = psl_pkg::sat_inc(r_len);
                    end else begin
                        do_flush = 1'b1; do_start = 1'b1;
                    end
                end
                psl_pkg::M_FRAC: begin
                    if (psl_pkg::is_digit(c)) n_len = psl_pkg::sat_inc(r_len);
                    else begin
                        do_flush = 1'b1; do_start = 1'b1;
                    end
                end
                psl_pkg::M_HOLD: begin
                    if (r_pend == "(" && c == "*") n_mode = psl_pkg::M_PCOM;
                    else if (psl_pkg::pair_code(r_pend, c) != psl_pkg::TK_NONE) begin
                        e0 = mk(psl_pkg::pair_code(r_pend, c), r_line, r_start,
                                CW'(2), r_pend);
                        e0v = 1'b1;
                        n_mode = psl_pkg::M_IDLE;
                    end else begin
                        do_flush = 1'b1; do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase
        end
        if (do_flush) begin
            n_mode = psl_pkg::M_IDLE;
            case (r_mode)
                psl_pkg::M_WORD: begin
                    e0 = mk(kw_code, r_line, r_start, r_len, r_pend); e0v = 1'b1;
                end
                psl_pkg::M_INT, psl_pkg::M_FRAC: begin
                    e0 = mk(psl_pkg::TK_NUMBER, r_line, r_start, r_len, r_pend);
                    e0v = 1'b1;
                end
                psl_pkg::M_HOLD: begin
                    e0 = mk(psl_pkg::single_code(r_pend), r_line, r_start, CW'(1),
                            r_pend);
                    e0v = 1'b1;
                end
                default: ;
            endcase
        end
        if (do_start) begin
            n_mode = psl_pkg::M_IDLE;
            if (c == "{") n_mode = psl_pkg::M_BRACE;
            else if (!psl_pkg::is_blank(c)) begin
                n_pend = c; n_start = r_col; n_len = CW'(1);
                if (psl_pkg::is_alpha(c)) begin
                    n_pfx = '0;
                    n_pfx[(KL-1)*8 +: 8] = c;
                    n_mode = psl_pkg::M_WORD;
                end else if (psl_pkg::is_digit(c)) n_mode = psl_pkg::M_INT;
                else if (c == "(" || c == ":" || c == "<" || c == ">" || c == "+"
                         || c == "-") n_mode = psl_pkg::M_HOLD;
                else begin
                    e1 = mk(psl_pkg::single_code(c), r_line, r_col, CW'(1), c);
                    e1v = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        psl_pkg::t_out_item a, b;
        logic av, bv;
        a = e0; b = e1; av = e0v; bv = e1v;
        if (!e0v) begin
            a = e1; av = e1v; bv = 1'b0;
        end
        if (av && !bv) a.last = 1'b1;
        if (bv) b.last = 1'b1;
        if (!i_rst_n) begin
            r_mode <= psl_pkg::M_IDLE; r_pend <= '0; r_pfx <= '0;
            r_start <= CW'(1); r_len <= '0; r_line <= CW'(1); r_col <= CW'(1);
            r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else begin
            if (take) begin
                r_mode <= n_mode; r_pend <= n_pend; r_pfx <= n_pfx;
                r_start <= n_start; r_len <= n_len; r_line <= n_line; r_col <= n_col;
            end
            // take implies r_v1 low and q0 empty or draining now.
            if (take && av) begin
                r_v0 <= 1'b1; r_q0 <= a;
                r_v1 <= bv; r_q1 <= b;
            end else if (r_v0 && !i_stall) begin
                // Advance the queue: q1 moves up when q0 is taken.
                r_v0 <= r_v1; r_q0 <= r_q1; r_v1 <= 1'b0;
            end
        end
    end
endmodule

/* hw/rtl/psl_kw_match.sv */
// Keyword lookup: compares the stored word prefix with the keyword table.
// Depends on psl_pkg.
module psl_kw_match (
    input  psl_pkg::t_prefix             i_prefix,
    input  logic [psl_pkg::CountWidth-1:0] i_len,
    output logic [6:0]                   o_code
);
    // Prefix bytes past the length are zero since the word slots are cleared
    // on start, so a whole-buffer compare matches exact length too.
    always_comb begin
        o_code = psl_pkg::TK_IDENT;
        if (i_len <= psl_pkg::CountWidth'(psl_pkg::KwMaxLen)) begin
            for (int k = 39; k >= 0; k--) begin
                if (i_prefix == psl_pkg::kw_text(k)) o_code = 7'(k);
            end
        end
    end
endmodule

/* hw/rtl/psl_checker.sv */
// Port-level checker for pascal_subset_lexer_unit, bound into each instance of it.
// Depends on psl_pkg.
module psl_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input psl_pkg::t_out_item o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("result dropped");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall) else $error("input taken while output blocked");
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.line_no != 16'd0 && o_data.lexeme_length != 16'd0)
        else $error("zero line or empty lexeme");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.token_code <= 7'd65 && o_data.token_code != 7'd43
        && o_data.token_code != 7'd62) else $error("bad token code");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind pascal_subset_lexer_unit psl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench for pascal_subset_lexer_unit: directed table then random source text,
// checked against an in-bench token predictor. Depends on psl_pkg and the RTL.
module tb;

    typedef enum logic [2:0] {
        S_IDLE, S_WORD, S_INT, S_FRAC, S_BRACE, S_PCOM, S_PSTAR, S_HOLD
    } t_scan_state;

    typedef struct {
        logic               cmd;
        logic [7:0]         ch;
        logic               has_tok;
        psl_pkg::t_out_item tok;
    } t_table_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    psl_pkg::t_in_item  i_data;
    logic               o_valid;
    logic               i_stall;
    psl_pkg::t_out_item o_data;

    pascal_subset_lexer_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    // predictor state
    t_scan_state lx_state;
    logic [7:0]  lx_first;
    logic [7:0]  lx_prefix [psl_pkg::KwMaxLen];
    logic [15:0] lx_start_col;
    logic [15:0] lx_len;
    logic [15:0] lx_line;
    logic [15:0] lx_col;

    psl_pkg::t_out_item token_queue [$];
    psl_pkg::t_out_item step_toks [$];
    int          fail_count;
    int          token_count;
    int          item_count;
    int          eol_count;
    longint      cycle_count;
    logic        quiet_mode;
    logic        long_hold;
    string       kw_names [40];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [6:0] sym_code(input logic [7:0] c);
        case (c)
            "+": return 7'd46;  "-": return 7'd47;  "*": return 7'd48;
            "/": return 7'd49;  "^": return 7'd55;  "=": return 7'd45;
            ";": return 7'd56;  ",": return 7'd57;  "(": return 7'd58;
            ")": return 7'd59;  "[": return 7'd60;  "]": return 7'd61;
            "}": return 7'd63;  ".": return 7'd64;  ":": return 7'd65;
            default: return psl_pkg::TK_SYMBOL;
        endcase
    endfunction

    function automatic logic [6:0] op_pair(input logic [7:0] a, input logic [7:0] b);
        if (a == ":" && b == "=") return psl_pkg::TK_ASSIGN;
        if (a == "<" && b == ">") return psl_pkg::TK_NE;
        if (a == "<" && b == "=") return psl_pkg::TK_LE;
        if (a == ">" && b == "=") return psl_pkg::TK_GE;
        if (a == "+" && b == "+") return psl_pkg::TK_INC;
        if (a == "-" && b == "-") return psl_pkg::TK_DEC;
        return psl_pkg::TK_NONE;
    endfunction

    function automatic bit c_blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction
    function automatic bit c_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit c_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [6:0] classify_word();
        string w;
        bit    hit;
        w = "";
        if (lx_len > psl_pkg::KwMaxLen) return psl_pkg::TK_IDENT;
        for (int i = 0; i < lx_len; i++) w = {w, string'(lx_prefix[i])};
        for (int k = 0; k < 40; k++) begin
            hit = (kw_names[k] == w);
            if (hit) return 7'(k);
        end
        return psl_pkg::TK_IDENT;
    endfunction

    task automatic push_tok(input logic [6:0] code, input logic [15:0] col,
                            input logic [15:0] len, input logic [7:0] first);
        psl_pkg::t_out_item t;
        t.token_code    = code;
        t.line_no       = lx_line;
        t.col_no        = col;
        t.lexeme_length = len;
        t.first_byte    = first;
        t.last          = 1'b0;
        step_toks.insert(step_toks.size(), t);
    endtask

    task automatic close_token();
        case (lx_state)
            S_WORD:         push_tok(classify_word(), lx_start_col, lx_len, lx_first);
            S_INT, S_FRAC:  push_tok(psl_pkg::TK_NUMBER, lx_start_col, lx_len, lx_first);
            S_HOLD:         push_tok(sym_code(lx_first), lx_start_col, 16'd1, lx_first);
            default: ;
        endcase
        lx_state = S_IDLE;
    endtask

    task automatic open_token(input logic [7:0] c);
        lx_state = S_IDLE;
        if (c_blank(c)) return;
        if (c == "{") begin
            lx_state = S_BRACE;
            return;
        end
        lx_first     = c;
        lx_start_col = lx_col;
        lx_len       = 16'd1;
        if (c_alpha(c)) begin
            lx_prefix[0] = c;
            lx_state = S_WORD;
        end else if (c_digit(c)) begin
            lx_state = S_INT;
        end else if (c == "(" || c == ":" || c == "<" || c == ">" || c == "+" || c == "-") begin
            lx_state = S_HOLD;
        end else begin
            push_tok(sym_code(c), lx_col, 16'd1, c);
        end
    endtask

    task automatic scan_byte(input logic [7:0] c);
        logic [6:0] pc;
        case (lx_state)
            S_BRACE: begin
                if (c == "}") lx_state = S_IDLE;
                return;
            end
            S_PCOM: begin
                if (c == "*") lx_state = S_PSTAR;
                return;
            end
            S_PSTAR: begin
                if (c == ")") lx_state = S_IDLE;
                else if (c != "*") lx_state = S_PCOM;
                return;
            end
            S_WORD: if (c_alpha(c) || c_digit(c) || c == "_") begin
                if (lx_len < psl_pkg::KwMaxLen) lx_prefix[lx_len] = c;
                lx_len = inc16(lx_len);
                return;
            end
            S_INT: if (c_digit(c) || c == ".") begin
                if (c == ".") lx_state = S_FRAC;
                lx_len = inc16(lx_len);
                return;
            end
            S_FRAC: if (c_digit(c)) begin
                lx_len = inc16(lx_len);
                return;
            end
            S_HOLD: begin
                if (lx_first == "(" && c == "*") begin
                    lx_state = S_PCOM;
                    return;
                end
                pc = op_pair(lx_first, c);
                if (pc != psl_pkg::TK_NONE) begin
                    push_tok(pc, lx_start_col, 16'd2, lx_first);
                    lx_state = S_IDLE;
                    return;
                end
            end
            default: ;
        endcase
        close_token();
        open_token(c);
    endtask

    // Predict tokens for one item into step_toks, mark last.
    task automatic predict_tokens(input psl_pkg::t_in_item it);
        step_toks.delete();
        if (it.cmd == psl_pkg::CMD_EOL) begin
            close_token();
            lx_line = inc16(lx_line);
            lx_col  = 16'd1;
        end else begin
            scan_byte(it.ch);
            lx_col = inc16(lx_col);
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    endtask

    task automatic send_item(input psl_pkg::t_in_item it);
        bit gap;
        gap = !quiet_mode && ($urandom_range(0, 99) < 10);
        while (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            gap = $urandom_range(0, 99) < 10;
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_tokens(it);
        foreach (step_toks[k]) token_queue.insert(token_queue.size(), step_toks[k]);
        item_count++;
        if (it.cmd == psl_pkg::CMD_EOL) eol_count++;
    endtask

    task automatic send_text(input string s);
        psl_pkg::t_in_item it;
        for (int i = 0; i < s.len(); i++) begin
            it.cmd = psl_pkg::CMD_CHAR;
            it.ch  = s[i];
            send_item(it);
        end
    endtask

    task automatic send_eol();
        psl_pkg::t_in_item it;
        it.cmd = psl_pkg::CMD_EOL;
        it.ch  = 8'($urandom);
        send_item(it);
    endtask

    task automatic drain_tokens();
        i_valid <= 1'b0;
        while (token_queue.size() > 0) @(posedge i_clk);
    endtask

    function automatic string random_piece();
        string s;
        string syms;
        int    n;
        s = "";
        syms = "+-*/^=;,()[]}.:<>_";
        case ($urandom_range(0, 11))
            0, 1: s = kw_names[$urandom_range(0, 39)];
            2: begin
                n = $urandom_range(1, 14);
                s = string'(8'("a" + $urandom_range(0, 25)));
                for (int i = 1; i < n; i++)
                    case ($urandom_range(0, 3))
                        0: s = {s, string'(8'("0" + $urandom_range(0, 9)))};
                        1: s = {s, "_"};
                        2: s = {s, string'(8'("A" + $urandom_range(0, 25)))};
                        default: s = {s, string'(8'("a" + $urandom_range(0, 25)))};
                    endcase
            end
            3: begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
                if ($urandom_range(0, 1)) s = {s, "."};
                if ($urandom_range(0, 1)) s = {s, "7", "."};
            end
            4: case ($urandom_range(0, 5))
                0: s = ":="; 1: s = "<>"; 2: s = "<="; 3: s = ">="; 4: s = "++";
                default: s = "--";
            endcase
            5: s = string'(8'($urandom_range(0, 255)));
            6: s = "{ x := 1 }";
            7: s = ($urandom_range(0, 1)) ? "(* note **)" : "(* open";
            8: s = "{ open";
            9: s = string'(syms[$urandom_range(0, 17)]);
            default: s = ($urandom_range(0, 1)) ? " " : "\t";
        endcase
        return s;
    endfunction

    // Receiver: random stalls plus one long hold-off.
    initial begin
        int hold;
        i_stall   = 1'b0;
        long_hold = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                hold = 0;
                while (hold < 300) begin
                    @(posedge i_clk);
                    hold++;
                end
                long_hold = 1'b0;
                i_stall <= 1'b0;
            end else begin
                i_stall <= !quiet_mode && ($urandom_range(0, 99) < 10);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        psl_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (token_queue.size() == 0) begin
                $error("token with none expected: code %0d", o_data.token_code);
                fail_count++;
            end else begin
                want = token_queue.pop_front();
                token_count++;
                if (o_data.token_code !== want.token_code) begin
                    $error("token_code exp %0d got %0d", want.token_code, o_data.token_code);
                    fail_count++;
                end
                if (o_data.line_no !== want.line_no) begin
                    $error("line_no exp %0d got %0d", want.line_no, o_data.line_no);
                    fail_count++;
                end
                if (o_data.col_no !== want.col_no) begin
                    $error("col_no exp %0d got %0d", want.col_no, o_data.col_no);
                    fail_count++;
                end
                if (o_data.lexeme_length !== want.lexeme_length) begin
                    $error("lexeme_length exp %0d got %0d", want.lexeme_length,
                           o_data.lexeme_length);
                    fail_count++;
                end
                if (o_data.first_byte !== want.first_byte) begin
                    $error("first_byte exp %0h got %0h", want.first_byte, o_data.first_byte);
                    fail_count++;
                end
                if (o_data.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, o_data.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic psl_pkg::t_out_item mk(input logic [6:0] c, input int ln,
                                              input int col, input int len,
                                              input logic [7:0] f, input logic l);
        psl_pkg::t_out_item t;
        t.token_code = c; t.line_no = 16'(ln); t.col_no = 16'(col);
        t.lexeme_length = 16'(len); t.first_byte = f; t.last = l;
        return t;
    endfunction

    initial begin
        t_table_row        rows [$];
        t_table_row        r;
        psl_pkg::t_in_item it;
        int                tgt;
        string             s;
        kw_names = '{"program", "read", "write", "integer", "boolean", "double",
                     "function", "procedure", "begin", "end", "and", "array", "case",
                     "const", "div", "do", "downto", "else", "file", "for", "goto", "if",
                     "in", "label", "mod", "nil", "not", "of", "or", "packed", "record",
                     "repeat", "set", "then", "to", "type", "until", "with", "var",
                     "while"};
        fail_count = 0; token_count = 0; item_count = 0; eol_count = 0;
        quiet_mode = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        i_rst_n = 1'b0;
        lx_state = S_IDLE; lx_first = '0; lx_start_col = 16'd1; lx_len = '0;
        lx_line = 16'd1; lx_col = 16'd1;
        foreach (lx_prefix[i]) lx_prefix[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: typed expectation where obvious, else predictor.
        r.has_tok = 1'b0; r.cmd = psl_pkg::CMD_CHAR;
        r.ch = ";";   r.has_tok = 1'b1; r.tok = mk(7'd56, 1, 1, 1, ";", 1'b1); rows = {rows, r};
        r.ch = 8'hFF; r.tok = mk(psl_pkg::TK_SYMBOL, 1, 2, 1, 8'hFF, 1'b1); rows = {rows, r};
        r.ch = 8'h00; r.tok = mk(psl_pkg::TK_SYMBOL, 1, 3, 1, 8'h00, 1'b1); rows = {rows, r};
        r.ch = "}";   r.tok = mk(7'd63, 1, 4, 1, "}", 1'b1); rows = {rows, r};
        r.ch = "_";   r.tok = mk(psl_pkg::TK_SYMBOL, 1, 5, 1, "_", 1'b1); rows = {rows, r};
        r.has_tok = 1'b0;
        r.ch = ":"; rows = {rows, r};
        r.ch = "="; rows = {rows, r};
        r.ch = "<"; rows = {rows, r};
        r.ch = ">"; rows = {rows, r};
        r.ch = "("; rows = {rows, r};
        r.ch = "*"; rows = {rows, r};
        r.ch = ")"; rows = {rows, r};
        r.ch = "a"; rows = {rows, r};
        r.ch = "1"; rows = {rows, r};
        r.ch = ";"; rows = {rows, r};
        r.ch = "9"; rows = {rows, r};
        r.ch = "."; rows = {rows, r};
        r.ch = "."; rows = {rows, r};
        r.ch = "-"; rows = {rows, r};
        r.cmd = psl_pkg::CMD_EOL; r.ch = 8'hA5; rows = {rows, r};
        r.cmd = psl_pkg::CMD_CHAR; r.ch = "{"; rows = {rows, r};
        r.ch = 8'h80; rows = {rows, r};
        r.cmd = psl_pkg::CMD_EOL; rows = {rows, r};
        foreach (rows[i]) begin
            it.cmd = rows[i].cmd;
            it.ch  = rows[i].ch;
            send_item(it);
            if (rows[i].has_tok && (step_toks.size() != 1 || step_toks[0] != rows[i].tok)) begin
                $error("directed row %0d: predictor disagrees with table", i);
                fail_count++;
            end
        end
        send_text("program procedure downto while if x:=1.5<>2<=3>=4++5--6");
        send_eol();
        drain_tokens();

        // Back-pressure: hold receiver off while offering items.
        long_hold = 1'b1;
        send_text("a;b;c;d;e;f;g;h;(1)(2)[3]");
        send_eol();
        drain_tokens();

        // Random source lines
        tgt = 1150;
        while (item_count < tgt) begin
            quiet_mode = ((item_count / 200) % 3 == 2);
            s = random_piece();
            send_text(s);
            if ($urandom_range(0, 5) == 0) send_eol();
            else if ($urandom_range(0, 2) == 0) send_text(" ");
        end
        quiet_mode = 1'b0;
        send_eol();
        drain_tokens();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d items (%0d line ends), %0d tokens checked.",
                 item_count, eol_count, token_count);
        if (fail_count == 0 && token_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
